[sv/chse_pkg.sv]
package chse_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_KNOTS_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [1:0] ORD_VALUE = 2'd0;
    localparam logic [1:0] ORD_D1    = 2'd1;
    localparam logic [1:0] ORD_D2    = 2'd2;
    localparam logic [1:0] ORD_D3    = 2'd3;

    localparam logic signed [47:0] RES_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] RES_MIN = {1'b1, {47{1'b0}}};

    typedef struct packed {
        logic               action;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic signed [31:0] knot_slope;
        logic signed [31:0] query_x;
        logic [1:0]         derivative_order;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] result_value;
        logic [5:0]         interval_index;
        logic               clamped;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic     is_load;
        logic     load_ok;
        in_item_t item;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_t;

endpackage

[sv/chse_front.sv]
module chse_front #(
    parameter int MAX_KNOTS = chse_pkg::MAX_KNOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  chse_pkg::in_item_t s_data,
    output chse_pkg::queue_t   q_out,
    input  logic               q_pop
);

    localparam int QD = chse_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    chse_pkg::entry_t fifo_mem [QD];
    chse_pkg::entry_t entry_in;

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;

    assign s_ready = (count_reg != CW'(QD));
    assign push    = s_valid && s_ready;

    always_comb begin
        entry_in.item    = s_data;
        entry_in.is_load = (s_data.action == chse_pkg::ACT_LOAD);
        entry_in.load_ok = ({26'd0, s_data.knot_index} < 32'(MAX_KNOTS));
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= entry_in;
        end
    end

    assign q_out.valid = (count_reg != '0);
    assign q_out.entry = fifo_mem[rd_ptr_reg];

endmodule

[sv/chse_back.sv]
module chse_back #(
    parameter int MAX_KNOTS = chse_pkg::MAX_KNOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  chse_pkg::queue_t    q_in,
    output logic                q_pop,
    input  logic [6:0]          num_knots,
    output logic                m_valid,
    input  logic                m_ready,
    output chse_pkg::out_item_t m_data
);

    localparam int F   = chse_pkg::FRAC_BITS;
    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int DCW = $clog2(F + 1);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_RD_X0    = 5'd1;
    localparam logic [4:0] ST_RD_XL    = 5'd2;
    localparam logic [4:0] ST_CLAMP    = 5'd3;
    localparam logic [4:0] ST_SRCH_RD  = 5'd4;
    localparam logic [4:0] ST_SRCH_CMP = 5'd5;
    localparam logic [4:0] ST_RD_I     = 5'd6;
    localparam logic [4:0] ST_RD_I1    = 5'd7;
    localparam logic [4:0] ST_GET_I1   = 5'd8;
    localparam logic [4:0] ST_DIV_SET  = 5'd9;
    localparam logic [4:0] ST_DIV      = 5'd10;
    localparam logic [4:0] ST_T2       = 5'd11;
    localparam logic [4:0] ST_T3       = 5'd12;
    localparam logic [4:0] ST_WGT      = 5'd13;
    localparam logic [4:0] ST_M_Y0     = 5'd14;
    localparam logic [4:0] ST_M_Y1     = 5'd15;
    localparam logic [4:0] ST_M_B      = 5'd16;
    localparam logic [4:0] ST_M_D      = 5'd17;
    localparam logic [4:0] ST_SUM      = 5'd18;
    localparam logic [4:0] ST_H_LO     = 5'd19;
    localparam logic [4:0] ST_H_HI     = 5'd20;
    localparam logic [4:0] ST_ACC      = 5'd21;
    localparam logic [4:0] ST_OUT      = 5'd22;

    localparam logic signed [23:0] W_ONE = 24'sd1 <<< F;

    logic signed [31:0] x_mem [MAX_KNOTS];
    logic signed [31:0] y_mem [MAX_KNOTS];
    logic signed [31:0] m_mem [MAX_KNOTS];
    logic signed [31:0] x_rd_reg, y_rd_reg, m_rd_reg;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               wr_en;

    logic [4:0]         state_reg, state_next;
    logic [AW:0]        n_reg, n_next;
    logic [AW-1:0]      lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [AW:0]        mid_sum;
    logic signed [31:0] q_reg, q_next, x0_reg, x0_next;
    logic [1:0]         order_reg, order_next;
    logic               clamp_reg, clamp_next;
    logic signed [31:0] xi_reg, xi_next, yi_reg, yi_next, mi_reg, mi_next;
    logic signed [31:0] yi1_reg, yi1_next, mi1_reg, mi1_next;
    logic signed [32:0] d_reg, d_next, h_reg, h_next;
    logic [32:0]        rem_reg, rem_next;
    logic [33:0]        rem2;
    logic [DCW-1:0]     dcnt_reg, dcnt_next;
    logic [F:0]         t_reg, t_next, t2_reg, t2_next;
    logic signed [23:0] wa_reg, wa_next, wb_reg, wb_next;
    logic signed [23:0] wc_reg, wc_next, wd_reg, wd_next;
    logic signed [23:0] s1, s2, s3;
    logic signed [56:0] sm_reg, sm_next, s_reg, s_next;
    logic signed [95:0] acc_reg, acc_next, prod_ext;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg;
    logic               res_valid_reg, res_valid_next;
    chse_pkg::out_item_t res_reg, res_next;
    int                 n_int;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
    assign mid      = mid_sum[AW:1];
    assign rem2     = {rem_reg, 1'b0};
    assign prod_ext = 96'(prod_reg);
    assign s1       = 24'(t_reg);
    assign s2       = 24'(t2_reg);
    assign s3       = 24'(prod_reg[F+F:F]);
    assign n_int    = (int'(num_knots) < 2) ? 2 :
                      (int'(num_knots) > MAX_KNOTS) ? MAX_KNOTS : int'(num_knots);

    assign wr_en   = (state_reg == ST_IDLE) && q_in.valid && q_in.entry.is_load
                     && q_in.entry.load_ok;
    assign wr_addr = AW'(q_in.entry.item.knot_index);

    always_comb begin
        case (state_reg)
            ST_RD_XL:   rd_addr = AW'(n_reg - 1'b1);
            ST_SRCH_RD: rd_addr = mid;
            ST_RD_I:    rd_addr = lo_reg;
            ST_RD_I1:   rd_addr = lo_reg + 1'b1;
            default:    rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= q_in.entry.item.knot_x;
            y_mem[wr_addr] <= q_in.entry.item.knot_y;
            m_mem[wr_addr] <= q_in.entry.item.knot_slope;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
        m_rd_reg <= m_mem[rd_addr];
    end

    always_comb begin
        case (state_reg)
            ST_T2: begin
                mul_a = 34'(t_reg);
                mul_b = 34'(t_reg);
            end
            ST_T3: begin
                mul_a = 34'(prod_reg[F+F:F]);
                mul_b = 34'(t_reg);
            end
            ST_M_Y0: begin
                mul_a = 34'(wa_reg);
                mul_b = 34'(yi_reg);
            end
            ST_M_Y1: begin
                mul_a = 34'(wc_reg);
                mul_b = 34'(yi1_reg);
            end
            ST_M_B: begin
                mul_a = 34'(wb_reg);
                mul_b = 34'(mi_reg);
            end
            ST_M_D: begin
                mul_a = 34'(wd_reg);
                mul_b = 34'(mi1_reg);
            end
            ST_H_LO: begin
                mul_a = {5'd0, s_reg[28:0]};
                mul_b = 34'(h_reg);
            end
            ST_H_HI: begin
                mul_a = 34'($signed(s_reg[56:29]));
                mul_b = 34'(h_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        q_next         = q_reg;
        x0_next        = x0_reg;
        order_next     = order_reg;
        clamp_next     = clamp_reg;
        xi_next        = xi_reg;
        yi_next        = yi_reg;
        mi_next        = mi_reg;
        yi1_next       = yi1_reg;
        mi1_next       = mi1_reg;
        d_next         = d_reg;
        h_next         = h_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        t_next         = t_reg;
        t2_next        = t2_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        wd_next        = wd_reg;
        sm_next        = sm_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !m_ready;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_in.valid) begin
                    q_pop = 1'b1;
                    if (!q_in.entry.is_load) begin
                        q_next     = q_in.entry.item.query_x;
                        order_next = q_in.entry.item.derivative_order;
                        n_next     = (AW + 1)'(n_int);
                        clamp_next = 1'b0;
                        state_next = ST_RD_X0;
                    end
                end
            end
            ST_RD_X0: state_next = ST_RD_XL;
            ST_RD_XL: begin
                x0_next    = x_rd_reg;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (q_reg < x0_reg) begin
                    q_next     = x0_reg;
                    clamp_next = 1'b1;
                end else if (q_reg > x_rd_reg) begin
                    q_next     = x_rd_reg;
                    clamp_next = 1'b1;
                end
                lo_next    = '0;
                hi_next    = AW'(n_reg - 2'd2);
                state_next = (n_reg > (AW + 1)'(2)) ? ST_SRCH_RD : ST_RD_I;
            end
            ST_SRCH_RD: state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (x_rd_reg <= q_reg) begin
                    lo_next = mid;
                end else begin
                    hi_next = mid - 1'b1;
                end
                state_next = (lo_next < hi_next) ? ST_SRCH_RD : ST_RD_I;
            end
            ST_RD_I: state_next = ST_RD_I1;
            ST_RD_I1: begin
                xi_next    = x_rd_reg;
                yi_next    = y_rd_reg;
                mi_next    = m_rd_reg;
                state_next = ST_GET_I1;
            end
            ST_GET_I1: begin
                yi1_next   = y_rd_reg;
                mi1_next   = m_rd_reg;
                h_next     = {x_rd_reg[31], x_rd_reg} - {xi_reg[31], xi_reg};
                d_next     = {q_reg[31], q_reg} - {xi_reg[31], xi_reg};
                state_next = ST_DIV_SET;
            end
            ST_DIV_SET: begin
                rem_next  = d_reg;
                dcnt_next = '0;
                t_next    = '0;
                if (h_reg <= 0 || d_reg <= 0) begin
                    state_next = ST_T2;
                end else if (d_reg >= h_reg) begin
                    t_next     = (F + 1)'(1) << F;
                    state_next = ST_T2;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem2 >= {1'b0, h_reg}) begin
                    rem_next = 33'(rem2 - {1'b0, h_reg});
                    t_next   = {t_reg[F-1:0], 1'b1};
                end else begin
                    rem_next = rem2[32:0];
                    t_next   = {t_reg[F-1:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(F - 1)) begin
                    state_next = ST_T2;
                end
            end
            ST_T2: state_next = ST_T3;
            ST_T3: begin
                t2_next    = prod_reg[F+F:F];
                state_next = ST_WGT;
            end
            ST_WGT: begin
                case (order_reg)
                    chse_pkg::ORD_VALUE: begin
                        wa_next = 24'(2 * s3 - 3 * s2 + W_ONE);
                        wb_next = 24'(s3 - 2 * s2 + s1);
                        wc_next = 24'(3 * s2 - 2 * s3);
                        wd_next = 24'(s3 - s2);
                    end
                    chse_pkg::ORD_D1: begin
                        wa_next = 24'(6 * s2 - 6 * s1);
                        wb_next = 24'(3 * s2 - 4 * s1 + W_ONE);
                        wc_next = 24'(6 * s1 - 6 * s2);
                        wd_next = 24'(3 * s2 - 2 * s1);
                    end
                    chse_pkg::ORD_D2: begin
                        wa_next = 24'(12 * s1 - 6 * W_ONE);
                        wb_next = 24'(6 * s1 - 4 * W_ONE);
                        wc_next = 24'(6 * W_ONE - 12 * s1);
                        wd_next = 24'(6 * s1 - 2 * W_ONE);
                    end
                    default: begin
                        wa_next = 24'(12 * W_ONE);
                        wb_next = 24'(6 * W_ONE);
                        wc_next = 24'(-12 * W_ONE);
                        wd_next = 24'(6 * W_ONE);
                    end
                endcase
                state_next = ST_M_Y0;
            end
            ST_M_Y0: state_next = ST_M_Y1;
            ST_M_Y1: begin
                acc_next   = prod_ext <<< F;
                state_next = ST_M_B;
            end
            ST_M_B: begin
                acc_next   = acc_reg + (prod_ext <<< F);
                state_next = ST_M_D;
            end
            ST_M_D: begin
                sm_next    = 57'(prod_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                s_next     = sm_reg + 57'(prod_reg);
                state_next = ST_H_LO;
            end
            ST_H_LO: state_next = ST_H_HI;
            ST_H_HI: begin
                acc_next   = acc_reg + prod_ext;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_reg + (prod_ext <<< 29);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!res_valid_reg || m_ready) begin
                    res_valid_next         = 1'b1;
                    res_next.interval_index = 6'(lo_reg);
                    res_next.clamped        = clamp_reg;
                    if ((&acc_reg[95:79]) || !(|acc_reg[95:79])) begin
                        res_next.result_value = acc_reg[79:32];
                        res_next.saturated    = 1'b0;
                    end else begin
                        res_next.result_value = acc_reg[95] ? chse_pkg::RES_MIN
                                                            : chse_pkg::RES_MAX;
                        res_next.saturated    = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        q_reg     <= q_next;
        x0_reg    <= x0_next;
        order_reg <= order_next;
        clamp_reg <= clamp_next;
        xi_reg    <= xi_next;
        yi_reg    <= yi_next;
        mi_reg    <= mi_next;
        yi1_reg   <= yi1_next;
        mi1_reg   <= mi1_next;
        d_reg     <= d_next;
        h_reg     <= h_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        t_reg     <= t_next;
        t2_reg    <= t2_next;
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
        wc_reg    <= wc_next;
        wd_reg    <= wd_next;
        sm_reg    <= sm_next;
        s_reg     <= s_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

endmodule

[sv/cubic_hermite_spline_eval_core.sv]
// Cubic Hermite spline evaluator.
// Input channel s_*: valid/ready, one transaction per item. A load item writes
// one knot (x, y, slope) at knot_index; an evaluate item returns one result
// on m_* (valid/ready): value or derivative in t, left knot index, clamp and
// saturation flags. Load items return nothing.
// cfg_wr_en/cfg_wr_data set the knot count (reset 2); write only while idle.
// Items pass through a two-entry queue into a sequential engine, so up to two
// items are taken while the engine is busy.
// An evaluate item makes p binary-search probes (at most ceil(log2(n-1))),
// each through the registered table read; a bit-serial divider then forms t,
// skipped when t is 0 or 1. The shared 34x34 multiplier is used eight times.
// The engine finishes one evaluate item before it takes the next; a load item
// is written to the knot tables while the engine is idle.
// The result sits in an output register; if the receiver stalls, the engine
// holds the next result until the register frees, and the queue keeps filling.
// Reset empties the queue and the output register and sets the knot count to
// 2; the knot tables are not cleared.
module cubic_hermite_spline_eval_core #(
    parameter int MAX_KNOTS = chse_pkg::MAX_KNOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  chse_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output chse_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data
);

    chse_pkg::queue_t q_bus;
    logic             q_pop;
    logic [6:0]       num_knots_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_knots_reg <= 7'd2;
        end else if (cfg_wr_en) begin
            num_knots_reg <= cfg_wr_data;
        end
    end

    chse_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_out   (q_bus),
        .q_pop   (q_pop)
    );

    chse_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_in      (q_bus),
        .q_pop     (q_pop),
        .num_knots (num_knots_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[sv/chse_checker.sv]
module chse_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input chse_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    a_sat_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            m_data.result_value == chse_pkg::RES_MAX ||
            m_data.result_value == chse_pkg::RES_MIN)
        else $error("saturated flag without limit value");

endmodule

bind cubic_hermite_spline_eval_core chse_checker u_chse_checker (.*);
